>>> rtl/dq_pkg.sv
// Shared types, codes and widths for the double-ended queue.
package dq_pkg;

   localparam int unsigned DEPTH_DEFAULT = 16;

   localparam int unsigned REQ_TYPE_W    = 3;
   localparam int unsigned VALUE_W       = 32;
   localparam int unsigned STATUS_W      = 2;
   localparam int unsigned ENTRY_COUNT_W = 5;
   localparam int unsigned OP_W          = 4;

   // request kinds
   localparam logic [REQ_TYPE_W-1:0] REQ_PUSH_FRONT = 3'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_PUSH_BACK  = 3'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_POP_FRONT  = 3'd2;
   localparam logic [REQ_TYPE_W-1:0] REQ_POP_BACK   = 3'd3;
   localparam logic [REQ_TYPE_W-1:0] REQ_LIST       = 3'd4;
   localparam logic [REQ_TYPE_W-1:0] REQ_CLEAR      = 3'd5;

   // result status
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   // datapath operations
   localparam logic [OP_W-1:0] OP_IDLE         = 4'd0;
   localparam logic [OP_W-1:0] OP_PUSH_FRONT   = 4'd1;
   localparam logic [OP_W-1:0] OP_PUSH_BACK    = 4'd2;
   localparam logic [OP_W-1:0] OP_POP_FRONT    = 4'd3;
   localparam logic [OP_W-1:0] OP_POP_BACK     = 4'd4;
   localparam logic [OP_W-1:0] OP_LIST_FIRST   = 4'd5;
   localparam logic [OP_W-1:0] OP_LIST_NEXT    = 4'd6;
   localparam logic [OP_W-1:0] OP_CLEAR        = 4'd7;
   localparam logic [OP_W-1:0] OP_STATUS       = 4'd8;
   localparam logic [OP_W-1:0] OP_CAPTURE_POP  = 4'd9;
   localparam logic [OP_W-1:0] OP_CAPTURE_LIST = 4'd10;

   typedef struct packed {
      logic [REQ_TYPE_W-1:0]     req_type;
      logic signed [VALUE_W-1:0] push_value;
   } req_word_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0]   out_value;
      logic [STATUS_W-1:0]         status;
      logic [ENTRY_COUNT_W-1:0]    entry_count;
      logic                        last_of_run;
   } rsp_word_type;

   typedef struct packed {
      logic [OP_W-1:0]     op;
      logic [STATUS_W-1:0] status;
   } dq_cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
      logic rsp_last;
   } dq_stat_type;

endpackage

>>> rtl/dq_datapath.sv
// Entry store, front pointer, fill count and result register of the queue.
module dq_datapath
   import dq_pkg::*;
#(
   parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  dq_cmd_type                cmd,
   input  logic signed [VALUE_W-1:0] push_value,
   output dq_stat_type               stat,
   output rsp_word_type              rsp_word
);

   localparam int unsigned POS_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam int unsigned SUM_W = CNT_W + 1;

   logic signed [VALUE_W-1:0] mem [DEPTH];

   logic [POS_W-1:0]          front_ff, front_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [CNT_W-1:0]          idx_ff, idx_in;
   rsp_word_type              rsp_ff, rsp_in;
   logic signed [VALUE_W-1:0] rd_data_ff;

   logic                      wr_en;
   logic [POS_W-1:0]          wr_addr;
   logic [POS_W-1:0]          rd_addr;
   logic [POS_W-1:0]          front_inc, front_dec;
   logic                      load;
   logic signed [VALUE_W-1:0] load_value;
   logic [STATUS_W-1:0]       load_status;
   logic                      load_last;

   // ring position of the entry 'off' places behind the front
   function automatic logic [POS_W-1:0] slot_of(input logic [POS_W-1:0] base,
                                                input logic [CNT_W-1:0] off);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(base) + SUM_W'(off);
      if (sum >= SUM_W'(DEPTH)) begin
         sum = sum - SUM_W'(DEPTH);
      end
      return sum[POS_W-1:0];
   endfunction

   assign front_inc = (front_ff == POS_W'(DEPTH - 1)) ? '0 : front_ff + POS_W'(1);
   assign front_dec = (front_ff == '0) ? POS_W'(DEPTH - 1) : front_ff - POS_W'(1);

   always_comb begin
      front_in    = front_ff;
      count_in    = count_ff;
      idx_in      = idx_ff;
      wr_en       = 1'b0;
      wr_addr     = front_dec;
      rd_addr     = front_ff;
      load        = 1'b0;
      load_value  = '0;
      load_status = ST_OK;
      load_last   = 1'b1;
      unique case (cmd.op)
         OP_PUSH_FRONT: begin
            wr_en     = 1'b1;
            wr_addr   = front_dec;
            front_in  = front_dec;
            count_in  = count_ff + CNT_W'(1);
            load      = 1'b1;
         end
         OP_PUSH_BACK: begin
            wr_en     = 1'b1;
            wr_addr   = slot_of(front_ff, count_ff);
            count_in  = count_ff + CNT_W'(1);
            load      = 1'b1;
         end
         OP_POP_FRONT: begin
            rd_addr   = front_ff;
            front_in  = front_inc;
            count_in  = count_ff - CNT_W'(1);
         end
         OP_POP_BACK: begin
            rd_addr   = slot_of(front_ff, count_ff - CNT_W'(1));
            count_in  = count_ff - CNT_W'(1);
         end
         OP_LIST_FIRST: begin
            rd_addr   = front_ff;
            idx_in    = '0;
         end
         OP_LIST_NEXT: begin
            rd_addr   = slot_of(front_ff, idx_ff + CNT_W'(1));
            idx_in    = idx_ff + CNT_W'(1);
         end
         OP_CLEAR: begin
            front_in  = '0;
            count_in  = '0;
            load      = 1'b1;
         end
         OP_STATUS: begin
            load        = 1'b1;
            load_status = cmd.status;
         end
         OP_CAPTURE_POP: begin
            load       = 1'b1;
            load_value = rd_data_ff;
         end
         OP_CAPTURE_LIST: begin
            load       = 1'b1;
            load_value = rd_data_ff;
            load_last  = (idx_ff + CNT_W'(1)) == count_ff;
         end
         default: begin
         end
      endcase

      rsp_in = rsp_ff;
      if (load) begin
         rsp_in.out_value   = load_value;
         rsp_in.status      = load_status;
         rsp_in.entry_count = ENTRY_COUNT_W'(count_in);
         rsp_in.last_of_run = load_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         count_ff <= '0;
         idx_ff   <= '0;
      end else begin
         front_ff <= front_in;
         count_ff <= count_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= push_value;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign stat.empty    = (count_ff == '0);
   assign stat.full     = (count_ff == CNT_W'(DEPTH));
   assign stat.rsp_last = rsp_ff.last_of_run;
   assign rsp_word      = rsp_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count above depth");

   a_front_bound: assert property (@(posedge clock) disable iff (reset)
      front_ff <= POS_W'(DEPTH - 1))
      else $error("front pointer outside ring");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_PUSH_FRONT || cmd.op == OP_PUSH_BACK)
      |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("push did not add one entry");

   a_list_nonempty: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_CAPTURE_LIST) |-> count_ff != '0)
      else $error("listing word captured from empty queue");
`endif

endmodule

>>> rtl/dq_ctrl.sv
// Request sequencer: decodes requests, steps listings, runs the handshakes.
module dq_ctrl
   import dq_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [REQ_TYPE_W-1:0] req_type,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  dq_stat_type           stat,
   output dq_cmd_type            cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_READ = 2'd1;
   localparam logic [1:0] S_RESP = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       list_ff, list_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);

   always_comb begin
      state_in   = state_ff;
      list_in    = list_ff;
      cmd.op     = OP_IDLE;
      cmd.status = ST_OK;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_RESP;
               list_in  = 1'b0;
               unique case (req_type)
                  REQ_PUSH_FRONT: begin
                     cmd.op     = stat.full ? OP_STATUS : OP_PUSH_FRONT;
                     cmd.status = stat.full ? ST_FULL : ST_OK;
                  end
                  REQ_PUSH_BACK: begin
                     cmd.op     = stat.full ? OP_STATUS : OP_PUSH_BACK;
                     cmd.status = stat.full ? ST_FULL : ST_OK;
                  end
                  REQ_POP_FRONT: begin
                     cmd.op     = stat.empty ? OP_STATUS : OP_POP_FRONT;
                     cmd.status = stat.empty ? ST_EMPTY : ST_OK;
                     state_in   = stat.empty ? S_RESP : S_READ;
                  end
                  REQ_POP_BACK: begin
                     cmd.op     = stat.empty ? OP_STATUS : OP_POP_BACK;
                     cmd.status = stat.empty ? ST_EMPTY : ST_OK;
                     state_in   = stat.empty ? S_RESP : S_READ;
                  end
                  REQ_LIST: begin
                     cmd.op     = stat.empty ? OP_STATUS : OP_LIST_FIRST;
                     cmd.status = stat.empty ? ST_EMPTY : ST_OK;
                     state_in   = stat.empty ? S_RESP : S_READ;
                     list_in    = 1'b1;
                  end
                  REQ_CLEAR: begin
                     cmd.op = OP_CLEAR;
                  end
                  default: begin
                     cmd.op = OP_STATUS;
                  end
               endcase
            end
         end
         S_READ: begin
            // store read data is registered, so it is valid in the cycle after the address
            cmd.op   = list_ff ? OP_CAPTURE_LIST : OP_CAPTURE_POP;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_ready) begin
               if (stat.rsp_last) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.op   = OP_LIST_NEXT;
                  state_in = S_READ;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         list_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         list_ff  <= list_in;
      end
   end

endmodule

>>> rtl/double_ended_queue_core.sv
// Top level of the bounded double-ended queue.
//
//   port group   dir   payload          accepted when
//   req_         in    req_word_type    req_valid && req_ready
//   rsp_         out   rsp_word_type    rsp_valid && rsp_ready
//
// Push, clear and rejected requests: accepted, result word in the next cycle.
// Pops: an extra S_READ state for the registered entry store read.
// Listing: per entry a store read (S_READ), then a word handoff (S_RESP) that waits for rsp_ready.
// One request at a time; req_ready drops until its last word is taken.
// Reset clears front pointer and count synchronously; the store is not cleared.
module double_ended_queue_core
   import dq_pkg::*;
#(
   parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_word
);

   dq_cmd_type  cmd;
   dq_stat_type stat;

   dq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_type  (req_word.req_type),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   dq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .push_value (req_word.push_value),
      .stat       (stat),
      .rsp_word   (rsp_word)
   );

endmodule

>>> test/double_ended_queue_core_tb.sv
// Self-checking testbench for the double-ended queue core: directed cases and random traffic.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import dq_pkg::*;

   localparam int unsigned QDEPTH = DEPTH_DEFAULT;
   localparam int unsigned PTR_W = $clog2(QDEPTH);
   localparam int unsigned RANDOM_ITEMS = 185;
   // codes the block leaves unused; they must still answer with one word
   localparam logic [REQ_TYPE_W-1:0] REQ_SPARE_A = 3'd6;
   localparam logic [REQ_TYPE_W-1:0] REQ_SPARE_B = 3'd7;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_word_type rsp_word;

   double_ended_queue_core #(.DEPTH(QDEPTH)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   // shadow copy of the queue
   logic signed [VALUE_W-1:0] shadow_store [QDEPTH];
   logic [PTR_W-1:0]          shadow_front = '0;
   logic [ENTRY_COUNT_W-1:0]  shadow_count = '0;

   rsp_word_type expected_words [$];
   int error_count = 0;
   int items_sent = 0;
   bit req_gaps_on = 1'b1;
   bit rsp_stalls_on = 1'b1;

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #1_000_000;
      $display("[double_ended_queue_core] ERROR");
      $finish;
   end

   function automatic int unsigned slot_at(int unsigned offset);
      return (shadow_front + offset) % QDEPTH;
   endfunction

   // Apply one accepted request to the shadow queue and queue up its words.
   function automatic void predict_words(req_word_type w);
      rsp_word_type r;
      r = '0;
      r.last_of_run = 1'b1;
      case (w.req_type)
         REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
            if (shadow_count == QDEPTH) begin
               r.status = ST_FULL;
            end else if (w.req_type == REQ_PUSH_FRONT) begin
               shadow_front = (shadow_front == 0) ? PTR_W'(QDEPTH - 1) : shadow_front - 1'b1;
               shadow_store[shadow_front] = w.push_value;
               shadow_count++;
            end else begin
               shadow_store[slot_at(shadow_count)] = w.push_value;
               shadow_count++;
            end
         end
         REQ_POP_FRONT, REQ_POP_BACK: begin
            if (shadow_count == 0) begin
               r.status = ST_EMPTY;
            end else if (w.req_type == REQ_POP_FRONT) begin
               r.out_value = shadow_store[shadow_front];
               shadow_front = (shadow_front == QDEPTH - 1) ? '0 : shadow_front + 1'b1;
               shadow_count--;
            end else begin
               r.out_value = shadow_store[slot_at(shadow_count - 1)];
               shadow_count--;
            end
         end
         REQ_LIST: begin
            if (shadow_count == 0) begin
               r.status = ST_EMPTY;
            end else begin
               for (int i = 0; i < shadow_count; i++) begin
                  r.out_value = shadow_store[slot_at(i)];
                  r.entry_count = shadow_count;
                  r.last_of_run = (i == shadow_count - 1);
                  expected_words.push_back(r);
               end
               return;
            end
         end
         REQ_CLEAR: begin
            shadow_front = '0;
            shadow_count = '0;
         end
         default: ;
      endcase
      r.entry_count = shadow_count;
      expected_words.push_back(r);
   endfunction

   function automatic void report_field(string field, longint want, longint got);
      error_count++;
      $display("%0t ns: %s expected %0d, got %0d", $time, field, want, got);
   endfunction

   // Result side: draws a stall per word and checks every accepted word.
   initial begin
      int stall;
      rsp_word_type want;
      stall = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               error_count++;
               $display({"%0t ns: unexpected word, expected none, ",
                         "got value %0d status %0d count %0d last %0b"},
                        $time, rsp_word.out_value, rsp_word.status, rsp_word.entry_count,
                        rsp_word.last_of_run);
            end else begin
               want = expected_words.pop_front();
               if (rsp_word.out_value !== want.out_value)
                  report_field("out_value", want.out_value, rsp_word.out_value);
               if (rsp_word.status !== want.status)
                  report_field("status", want.status, rsp_word.status);
               if (rsp_word.entry_count !== want.entry_count)
                  report_field("entry_count", want.entry_count, rsp_word.entry_count);
               if (rsp_word.last_of_run !== want.last_of_run)
                  report_field("last_of_run", want.last_of_run, rsp_word.last_of_run);
            end
            stall = rsp_stalls_on ? $urandom_range(0, 8) : 0;
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            stall--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Returns in the step the word is taken with valid still high; the next call
   // either keeps it up (no gap) or drops it.
   task automatic send_request(input logic [REQ_TYPE_W-1:0] kind,
                               input logic signed [VALUE_W-1:0] value);
      int gap;
      gap = req_gaps_on ? $urandom_range(0, 8) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= '{req_type: kind, push_value: value};
      do @(posedge clock); while (!req_ready);
      predict_words(req_word);
      items_sent++;
   endtask

   // Stop sending and hold off until every expected word is back.
   task automatic settle_requests();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_words.size() != 0);
   endtask

   task automatic send_random_request();
      int pick;
      logic [REQ_TYPE_W-1:0] kind;
      pick = $urandom_range(0, 19);
      if (pick < 5)       kind = REQ_PUSH_FRONT;
      else if (pick < 10) kind = REQ_PUSH_BACK;
      else if (pick < 13) kind = REQ_POP_FRONT;
      else if (pick < 16) kind = REQ_POP_BACK;
      else if (pick < 18) kind = REQ_LIST;
      else if (pick < 19) kind = REQ_CLEAR;
      else                kind = $urandom_range(0, 1) ? REQ_SPARE_A : REQ_SPARE_B;
      send_request(kind, $urandom);
   endtask

   task automatic test_empty_queue();
      send_request(REQ_POP_FRONT, $urandom);
      send_request(REQ_POP_BACK, $urandom);
      send_request(REQ_LIST, $urandom);
   endtask

   task automatic test_value_extremes();
      send_request(REQ_PUSH_BACK, 32'sh7FFF_FFFF);
      send_request(REQ_PUSH_FRONT, 32'sh8000_0000);
      send_request(REQ_PUSH_BACK, -32'sd1);
      send_request(REQ_PUSH_FRONT, 32'sd0);
      send_request(REQ_LIST, $urandom);
      send_request(REQ_POP_BACK, $urandom);
      send_request(REQ_POP_FRONT, $urandom);
   endtask

   task automatic test_spare_codes_and_clear();
      send_request(REQ_SPARE_A, 32'sh5555_5555);
      send_request(REQ_SPARE_B, 32'shAAAA_AAAA);
      send_request(REQ_CLEAR, $urandom);
      send_request(REQ_LIST, $urandom);
      send_request(REQ_POP_BACK, $urandom);
      settle_requests();
   endtask

   task automatic test_random_traffic();
      int start;
      int plan;
      start = items_sent;
      while (items_sent - start < RANDOM_ITEMS) begin
         req_gaps_on = $urandom_range(0, 3) != 0;
         rsp_stalls_on = $urandom_range(0, 3) != 0;
         plan = $urandom_range(0, 9);
         if (plan < 3) begin
            // fill from both ends, overflow at both ends, then a full listing
            while (shadow_count < QDEPTH)
               send_request($urandom_range(0, 1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK, $urandom);
            send_request(REQ_PUSH_FRONT, $urandom);
            send_request(REQ_PUSH_BACK, $urandom);
            send_request(REQ_LIST, $urandom);
         end else if (plan < 5) begin
            while (shadow_count > 0)
               send_request($urandom_range(0, 1) ? REQ_POP_FRONT : REQ_POP_BACK, $urandom);
            send_request($urandom_range(0, 1) ? REQ_POP_FRONT : REQ_POP_BACK, $urandom);
         end else if (plan < 9) begin
            repeat ($urandom_range(4, 12)) send_random_request();
         end else begin
            settle_requests();
            send_random_request();
         end
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_queue();
      test_value_extremes();
      test_spare_codes_and_clear();
      test_random_traffic();
      settle_requests();
      repeat (40) @(posedge clock);
      if (error_count == 0 && expected_words.size() == 0) begin
         $display("[double_ended_queue_core] OK");
      end else begin
         $display("[double_ended_queue_core] ERROR");
      end
      $finish;
   end

endmodule
